>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the stable matching engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked while reset is high.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/sme_pkg.sv
// Shared types and constants of the stable matching engine.
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD_MAN   = 2'd0,
      FUNC_LOAD_WOMAN = 2'd1,
      FUNC_RUN        = 2'd2
   } func_type;

   localparam int RESULT_LIMIT = 16;
   localparam int REG_PEOPLE_IN_USE = 0;
   localparam logic [4:0] PEOPLE_RESET = 5'd16;
   localparam logic [4:0] PARTNER_NONE = 5'h1F;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_pref;
      logic take;
      logic rclr;
      logic rb_read;
      logic rb_write;
      logic pop;
      logic prop;
      logic pw;
      logic pr;
      logic engage;
      logic dump;
      logic out_xfer;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
      logic q_empty;
      logic list_done;
      logic w_bad;
      logic rk_none;
      logic f_none;
      logic better;
      logic out_last;
   } status_type;

endpackage
`default_nettype wire

>>> hdl/stable_matching_engine.sv
// Top level of the stable matching engine: register port, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// The engine runs man-proposing deferred acceptance over preference lists that
// are loaded one entry per input transfer (func 0 for a man's list, func 1 for a
// woman's list); a load gives no result. After reset the block clears all P*P
// entries of both preference memories, P being the smaller of MAX_PEOPLE and 16,
// and takes no input transfer during that time. A run transfer (func 2) uses the
// first n people, n being people_in_use clamped to 1..P. The run clears and
// rebuilds the women's rank table, then pops free men from a queue; each
// proposal walks the man's list one entry at a time through a single-port rank
// memory. A man goes back into the queue only when he is dumped. The run then
// delivers n result transfers, one per man in index order, one per cycle while
// the consumer is ready; the last one carries last_result. The next input
// transfer is taken only after that.
module stable_matching_engine #(
   parameter int MAX_PEOPLE = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic [3:0]         req_person,
   input  wire logic [3:0]         req_position,
   input  wire logic signed [4:0]  req_choice,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [3:0]              rsp_man_index,
   output logic signed [4:0]       rsp_partner,
   output logic                    rsp_last_result,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   localparam int EFF = (MAX_PEOPLE < sme_pkg::RESULT_LIMIT) ? MAX_PEOPLE :
                        sme_pkg::RESULT_LIMIT;
   localparam int CW = $clog2(EFF) + 1;

   logic [4:0]          people_ff;
   logic [CW-1:0]       n;
   logic                csr_write, csr_hit;
   sme_pkg::cmd_type    cmd;
   sme_pkg::status_type st;

   // The only register sits at byte address zero; other addresses read zero.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr == 3'(sme_pkg::REG_PEOPLE_IN_USE * 4));
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {27'd0, people_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         people_ff <= sme_pkg::PEOPLE_RESET;
      end else if (csr_write && csr_hit) begin
         people_ff <= csr_pwdata[4:0];
      end
   end

   // A count of zero works as one; a count above the capacity saturates.
   always_comb begin
      priority if (people_ff == 5'd0) begin
         n = CW'(1);
      end else if (people_ff > 5'(EFF)) begin
         n = CW'(EFF);
      end else begin
         n = people_ff[CW-1:0];
      end
   end

   sme_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   sme_datapath #(.MAX_PEOPLE(MAX_PEOPLE)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .n               (n),
      .req_func        (req_func),
      .req_person      (req_person),
      .req_position    (req_position),
      .req_choice      (req_choice),
      .rsp_man_index   (rsp_man_index),
      .rsp_partner     (rsp_partner),
      .rsp_last_result (rsp_last_result)
   );

   // Results and new input transfers never overlap.
   `ASSERT_IMPLY(a_rsp_blocks_req, clock, reset, rsp_valid, !req_ready)
   // The memory clearing pass follows every reset.
   `ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_ready)
   // The last result of a run ends the result burst.
   `ASSERT_NEXT(a_last_ends_burst, clock, reset,
      rsp_valid && rsp_ready && rsp_last_result, !rsp_valid)
endmodule
`default_nettype wire

>>> hdl/sme_datapath.sv
// Datapath: preference and rank memories, matching tables, free-man queue.
`timescale 1ns / 1ps
`default_nettype none
module sme_datapath #(
   parameter int MAX_PEOPLE = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sme_pkg::cmd_type          cmd,
   output sme_pkg::status_type            st,
   input  wire logic [$clog2((MAX_PEOPLE < sme_pkg::RESULT_LIMIT) ? MAX_PEOPLE :
                       sme_pkg::RESULT_LIMIT):0] n,
   input  wire logic [1:0]                req_func,
   input  wire logic [3:0]                req_person,
   input  wire logic [3:0]                req_position,
   input  wire logic signed [4:0]         req_choice,
   output logic [3:0]                     rsp_man_index,
   output logic signed [4:0]              rsp_partner,
   output logic                           rsp_last_result
);
   localparam int EFF = (MAX_PEOPLE < sme_pkg::RESULT_LIMIT) ? MAX_PEOPLE :
                        sme_pkg::RESULT_LIMIT;
   localparam int IW = $clog2(EFF);
   localparam int CW = IW + 1;
   localparam int EW = IW + 1;
   localparam int AW = 2 * IW;
   localparam int DEPTH = 1 << AW;
   localparam logic [EW-1:0] ENTRY_NONE = {1'b1, {IW{1'b0}}};

   logic [EW-1:0] man_mem   [DEPTH];
   logic [EW-1:0] woman_mem [DEPTH];
   logic [EW-1:0] rank_mem  [DEPTH];
   logic [EW-1:0] rd_m_ff, rd_w_ff, rd_r_ff, rk_ff;

   logic [EW-1:0] fiancee_ff [EFF];
   logic [EW-1:0] fiance_ff  [EFF];
   logic [CW-1:0] next_ff    [EFF];
   logic [IW-1:0] queue_ff   [EFF];
   logic [IW-1:0] head_ff, tail_ff, m_ff, w_ff, f_ff;
   logic [CW-1:0] count_ff, a_ff, b_ff;

   logic [CW-1:0] lim;
   logic          b_last, sweep_step, load_ok, rb_ok;
   logic [IW-1:0] a_idx, b_idx, pos_cur, rd_m_idx, rd_w_idx;
   logic [EW-1:0] fiance_cur;
   logic [AW-1:0] rank_raddr;

   assign a_idx    = a_ff[IW-1:0];
   assign b_idx    = b_ff[IW-1:0];
   assign rd_m_idx = rd_m_ff[IW-1:0];
   assign rd_w_idx = rd_w_ff[IW-1:0];
   assign pos_cur  = next_ff[m_ff][IW-1:0];
   assign fiance_cur = fiance_ff[w_ff];

   assign lim        = cmd.clr_pref ? CW'(EFF) : n;
   assign b_last     = (b_ff == lim - CW'(1));
   assign sweep_step = cmd.clr_pref | cmd.rclr | cmd.rb_write;

   assign load_ok = cmd.take && (req_func != sme_pkg::FUNC_RUN) && (req_func[1] == 1'b0)
                    && ({1'b0, req_person} < 5'(n)) && ({1'b0, req_position} < 5'(n))
                    && !req_choice[4] && ({1'b0, req_choice[3:0]} < 5'(n));
   assign rb_ok   = !rd_w_ff[IW] && (CW'(rd_w_idx) < n);
   assign rank_raddr = cmd.pw ? {rd_m_idx, m_ff} : {w_ff, fiance_cur[IW-1:0]};

   always_comb begin
      st.sweep_last = b_last && (a_ff == lim - CW'(1));
      st.q_empty    = (count_ff == '0);
      st.list_done  = (next_ff[m_ff] >= n);
      st.w_bad      = rd_m_ff[IW] || (CW'(rd_m_idx) >= n);
      st.rk_none    = rd_r_ff[IW];
      st.f_none     = fiance_cur[IW];
      st.better     = !rd_r_ff[IW] && (rd_r_ff[IW-1:0] > rk_ff[IW-1:0]);
      st.out_last   = (b_ff == n - CW'(1));
   end

   // Sweep and result counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else if (cmd.take) begin
         a_ff <= '0;
         b_ff <= '0;
      end else if (sweep_step) begin
         if (b_last) begin
            b_ff <= '0;
            a_ff <= st.sweep_last ? '0 : a_ff + CW'(1);
         end else begin
            b_ff <= b_ff + CW'(1);
         end
      end else if (cmd.out_xfer) begin
         b_ff <= st.out_last ? '0 : b_ff + CW'(1);
      end
   end

   // Preference memories.
   always_ff @(posedge clock) begin
      if (cmd.clr_pref) begin
         man_mem[{a_idx, b_idx}]   <= ENTRY_NONE;
         woman_mem[{a_idx, b_idx}] <= ENTRY_NONE;
      end else if (load_ok) begin
         if (req_func == sme_pkg::FUNC_LOAD_MAN) begin
            man_mem[{req_person[IW-1:0], req_position[IW-1:0]}] <=
               {1'b0, req_choice[IW-1:0]};
         end else begin
            woman_mem[{req_person[IW-1:0], req_position[IW-1:0]}] <=
               {1'b0, req_choice[IW-1:0]};
         end
      end
      if (cmd.prop) begin
         rd_m_ff <= man_mem[{m_ff, pos_cur}];
      end
      if (cmd.rb_read) begin
         rd_w_ff <= woman_mem[{a_idx, b_idx}];
      end
   end

   // Rank memory: cleared and rebuilt at the start of each run.
   always_ff @(posedge clock) begin
      if (cmd.rclr) begin
         rank_mem[{a_idx, b_idx}] <= ENTRY_NONE;
      end else if (cmd.rb_write && rb_ok) begin
         rank_mem[{a_idx, rd_w_idx}] <= {1'b0, b_idx};
      end
      if (cmd.pw || cmd.pr) begin
         rd_r_ff <= rank_mem[rank_raddr];
      end
   end

   // Matching tables and free-man queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.take) begin
            head_ff  <= '0;
            tail_ff  <= (n == CW'(EFF)) ? '0 : n[IW-1:0];
            count_ff <= n;
         end else if (cmd.pop) begin
            head_ff  <= (head_ff == IW'(EFF - 1)) ? '0 : head_ff + IW'(1);
            count_ff <= count_ff - CW'(1);
         end else if (cmd.dump) begin
            tail_ff  <= (tail_ff == IW'(EFF - 1)) ? '0 : tail_ff + IW'(1);
            count_ff <= count_ff + CW'(1);
         end
      end
      if (cmd.rclr && (a_ff == '0)) begin
         fiance_ff[b_idx]  <= ENTRY_NONE;
         fiancee_ff[b_idx] <= ENTRY_NONE;
         next_ff[b_idx]    <= '0;
         queue_ff[b_idx]   <= b_idx;
      end
      if (cmd.pop) begin
         m_ff <= queue_ff[head_ff];
      end
      if (cmd.prop) begin
         next_ff[m_ff] <= next_ff[m_ff] + CW'(1);
      end
      if (cmd.pw) begin
         w_ff <= rd_m_idx;
      end
      if (cmd.pr) begin
         rk_ff <= rd_r_ff;
         f_ff  <= fiance_cur[IW-1:0];
      end
      if (cmd.dump) begin
         fiancee_ff[f_ff] <= ENTRY_NONE;
         queue_ff[tail_ff] <= f_ff;
      end
      if (cmd.engage) begin
         fiancee_ff[m_ff] <= {1'b0, w_ff};
         fiance_ff[w_ff]  <= {1'b0, m_ff};
      end
   end

   assign rsp_man_index   = 4'(b_idx);
   assign rsp_partner     = fiancee_ff[b_idx][IW] ? sme_pkg::PARTNER_NONE :
                            {1'b0, 4'(fiancee_ff[b_idx][IW-1:0])};
   assign rsp_last_result = st.out_last;
endmodule
`default_nettype wire

>>> hdl/sme_controller.sv
// Controller: state machine that sequences load, rebuild, matching and readout.
`timescale 1ns / 1ps
`default_nettype none
module sme_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_func,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire sme_pkg::status_type st,
   output sme_pkg::cmd_type         cmd
);
   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_RCLR, S_RB_RD, S_RB_WR, S_POP, S_PROP, S_PW, S_PR, S_PF, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_pref = 1'b1;
            if (st.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && req_func == sme_pkg::FUNC_RUN) state_in = S_RCLR;
         end
         S_RCLR: begin
            cmd.rclr = 1'b1;
            if (st.sweep_last) state_in = S_RB_RD;
         end
         S_RB_RD: begin
            cmd.rb_read = 1'b1;
            state_in = S_RB_WR;
         end
         S_RB_WR: begin
            cmd.rb_write = 1'b1;
            state_in = st.sweep_last ? S_POP : S_RB_RD;
         end
         S_POP: begin
            if (st.q_empty) begin
               state_in = S_OUT;
            end else begin
               cmd.pop = 1'b1;
               state_in = S_PROP;
            end
         end
         S_PROP: begin
            if (st.list_done) begin
               state_in = S_POP;
            end else begin
               cmd.prop = 1'b1;
               state_in = S_PW;
            end
         end
         S_PW: begin
            if (st.w_bad) begin
               state_in = S_PROP;
            end else begin
               cmd.pw = 1'b1;
               state_in = S_PR;
            end
         end
         S_PR: begin
            cmd.pr = 1'b1;
            priority if (st.rk_none) begin
               state_in = S_PROP;
            end else if (st.f_none) begin
               cmd.engage = 1'b1;
               state_in = S_POP;
            end else begin
               state_in = S_PF;
            end
         end
         S_PF: begin
            if (st.better) begin
               cmd.engage = 1'b1;
               cmd.dump   = 1'b1;
               state_in = S_POP;
            end else begin
               state_in = S_PROP;
            end
         end
         S_OUT: begin
            cmd.out_xfer = rsp_ready;
            if (rsp_ready && st.out_last) state_in = S_IDLE;
         end
         default: state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= (state_in == S_OUT);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire
